@@ design/smtb_pkg.sv @@
package smtb_pkg;

  localparam int INDEX_BYTES = 3;
  localparam int IDX_W       = 24;
  localparam int MAX_RES     = 8;
  localparam int CNT_W       = $clog2(MAX_RES + 1);

  // Result kinds
  localparam logic [2:0] K_TX   = 3'd0;
  localparam logic [2:0] K_RAMW = 3'd1;
  localparam logic [2:0] K_RAMR = 3'd2;
  localparam logic [2:0] K_FLW  = 3'd3;
  localparam logic [2:0] K_FLR  = 3'd4;

  // Command bytes
  localparam logic [7:0] C_FLASH_WRITE = 8'h70;
  localparam logic [7:0] C_FLASH_READ  = 8'h0F;
  localparam logic [7:0] C_FLASH_ERASE = 8'h38;
  localparam logic [7:0] C_RAM_WRITE   = 8'hF3;
  localparam logic [7:0] C_RAM_READ    = 8'h93;

  localparam logic [7:0] CKS_SEED   = 8'h23;
  localparam logic [7:0] ERASE_BUSY = 8'hCC;
  localparam logic [7:0] ERASE_DONE = 8'h33;

  // Flash command words
  localparam logic [31:0] FL_STATUS  = 32'h0000_0070;
  localparam logic [31:0] FL_ARRAY   = 32'h0000_00FF;
  localparam logic [31:0] FL_SETUP   = 32'h0000_0020;
  localparam logic [31:0] FL_CONFIRM = 32'h0000_00D0;

  typedef struct packed {
    logic        mode;
    logic [7:0]  rx_byte;
    logic [31:0] read_data;
  } smtb_in_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic [7:0]       tx_byte;
    logic [IDX_W-1:0] word_index;
    logic [31:0]      write_data;
    logic             last;
  } smtb_out_t;

  function automatic smtb_out_t mk(input logic [2:0] kind, input logic [7:0] tx,
                                   input logic [IDX_W-1:0] idx, input logic [31:0] data);
    smtb_out_t r;
    r.kind       = kind;
    r.tx_byte    = tx;
    r.word_index = idx;
    r.write_data = data;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

@@ design/serial_memory_transfer_bridge_unit.sv @@
// Channel  Handshake           Payload                         Direction
// in_      in_valid/in_stall   in_data  (mode, rx_byte, read)  into bridge
// out_     out_valid/out_stall out_data (kind, tx, index, ...)  out of bridge
//
// Each accepted transaction is decoded in the cycle it arrives; its 0 to 5
// results land in a result buffer and leave one per cycle while out_stall is
// low, through the one-wide drain of that buffer.
// The next input transaction is taken in the cycle the last result leaves.
// rst_n is synchronous, active low: phase returns to command wait, the
// checksum reseeds to 0x23 and the result buffer empties.
// out_stall holds the buffer head; in_stall is high while results remain, save as the last one leaves.
module serial_memory_transfer_bridge_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  smtb_pkg::smtb_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output smtb_pkg::smtb_out_t out_data
);
  import smtb_pkg::*;

  // Phase codes
  localparam logic [2:0] P_CMD        = 3'd0;
  localparam logic [2:0] P_INDEX      = 3'd1;
  localparam logic [2:0] P_RAMW_DATA  = 3'd2;
  localparam logic [2:0] P_RAMR_WAIT  = 3'd3;
  localparam logic [2:0] P_FLR_WAIT   = 3'd4;
  localparam logic [2:0] P_FLW_DATA   = 3'd5;
  localparam logic [2:0] P_FLW_POLL   = 3'd6;
  localparam logic [2:0] P_ERASE_POLL = 3'd7;

  localparam logic [2:0] IDX_BYTES_3 = 3'(INDEX_BYTES);
  localparam logic [2:0] IDX_TOTAL_3 = 3'(2 * INDEX_BYTES);

  logic [2:0]       phase_r, phase_nxt;
  logic [7:0]       command_r, command_nxt;
  logic [2:0]       byte_cnt_r, byte_cnt_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [IDX_W-1:0] end_r, end_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [31:0]      word_r, word_nxt;
  logic [7:0]       cks_r, cks_nxt;

  smtb_out_t        buf_r [MAX_RES];
  smtb_out_t        res   [MAX_RES];
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] n_res;

  logic in_acc, out_acc;

  assign out_valid = (cnt_r != '0);
  assign out_data  = buf_r[0];
  assign out_acc   = out_valid && !out_stall;
  // Accept only once the buffer is empty or its last entry leaves now
  assign in_stall  = (cnt_r > CNT_W'(1)) || ((cnt_r == CNT_W'(1)) && out_stall);
  assign in_acc    = in_valid && !in_stall;

  // Decode one transaction into next state and its result list
  always_comb begin
    logic [7:0]       c1, c2, c3, c4;
    logic [IDX_W-1:0] cur1;
    logic [IDX_W-1:0] st, en;
    logic [31:0]      w;
    logic [2:0]       bc1;
    logic             any;

    phase_nxt    = phase_r;
    command_nxt  = command_r;
    byte_cnt_nxt = byte_cnt_r;
    start_nxt    = start_r;
    end_nxt      = end_r;
    cur_nxt      = cur_r;
    word_nxt     = word_r;
    cks_nxt      = cks_r;
    n_res        = '0;
    for (int i = 0; i < MAX_RES; i++) res[i] = '0;

    c1   = cks_r ^ in_data.rx_byte;
    c2   = '0;
    c3   = '0;
    c4   = '0;
    cur1 = cur_r + IDX_W'(1);
    bc1  = byte_cnt_r + 3'd1;
    st   = start_r;
    en   = end_r;
    w    = word_r | (32'(in_data.rx_byte) << {byte_cnt_r[1:0], 3'b000});
    any  = 1'b0;

    if (!in_data.mode) begin
      unique case (phase_r)
        P_CMD: begin
          command_nxt  = in_data.rx_byte;
          cks_nxt      = CKS_SEED;
          byte_cnt_nxt = '0;
          start_nxt    = '0;
          end_nxt      = '0;
          phase_nxt    = P_INDEX;
        end
        P_INDEX: begin
          if (byte_cnt_r < IDX_BYTES_3) begin
            st = start_r | (IDX_W'(in_data.rx_byte) << {byte_cnt_r, 3'b000});
          end else begin
            en = end_r |
                 (IDX_W'(in_data.rx_byte) << {byte_cnt_r - IDX_BYTES_3, 3'b000});
          end
          start_nxt    = st;
          end_nxt      = en;
          byte_cnt_nxt = bc1;
          cks_nxt      = c1;
          if (bc1 >= IDX_TOTAL_3) begin
            // Echo, reseed, then launch the command
            res[0]       = mk(K_TX, c1, '0, '0);
            cks_nxt      = CKS_SEED;
            cur_nxt      = st;
            byte_cnt_nxt = '0;
            word_nxt     = '0;
            any          = st < en;
            n_res        = CNT_W'(2);
            res[1]       = mk(K_TX, CKS_SEED, '0, '0);
            unique case (command_r) inside
              C_RAM_WRITE, C_FLASH_WRITE: begin
                if (any) begin
                  phase_nxt = (command_r == C_RAM_WRITE) ? P_RAMW_DATA : P_FLW_DATA;
                  n_res     = CNT_W'(1);
                end else begin
                  cks_nxt   = '0;
                  phase_nxt = P_CMD;
                end
              end
              C_RAM_READ: begin
                if (any) begin
                  res[1]    = mk(K_RAMR, '0, st, '0);
                  phase_nxt = P_RAMR_WAIT;
                end else begin
                  cks_nxt   = '0;
                  phase_nxt = P_CMD;
                end
              end
              C_FLASH_READ: begin
                res[1] = mk(K_FLW, '0, '0, FL_ARRAY);
                n_res  = CNT_W'(3);
                if (any) begin
                  res[2]    = mk(K_FLR, '0, st, '0);
                  phase_nxt = P_FLR_WAIT;
                end else begin
                  res[2]    = mk(K_TX, CKS_SEED, '0, '0);
                  cks_nxt   = '0;
                  phase_nxt = P_CMD;
                end
              end
              C_FLASH_ERASE: begin
                res[1]    = mk(K_FLW, '0, '0, FL_SETUP);
                res[2]    = mk(K_FLW, '0, st, FL_CONFIRM);
                res[3]    = mk(K_FLW, '0, '0, FL_STATUS);
                res[4]    = mk(K_FLR, '0, '0, '0);
                n_res     = CNT_W'(5);
                phase_nxt = P_ERASE_POLL;
              end
              default: begin
                cks_nxt   = '0;
                phase_nxt = P_CMD;
              end
            endcase
          end
        end
        P_RAMW_DATA: begin
          cks_nxt      = c1;
          word_nxt     = w;
          byte_cnt_nxt = bc1;
          if (bc1 >= 3'd4) begin
            res[0]       = mk(K_RAMW, '0, cur_r, w);
            n_res        = CNT_W'(1);
            cur_nxt      = cur1;
            byte_cnt_nxt = '0;
            word_nxt     = '0;
            if (cur1 >= end_r) begin
              res[1]    = mk(K_TX, c1, '0, '0);
              n_res     = CNT_W'(2);
              cks_nxt   = '0;
              phase_nxt = P_CMD;
            end
          end
        end
        P_FLW_DATA: begin
          cks_nxt      = c1;
          word_nxt     = w;
          byte_cnt_nxt = bc1;
          if (bc1 >= 3'd2) begin
            res[0]    = mk(K_FLW, '0, '0, FL_SETUP);
            res[1]    = mk(K_FLW, '0, cur_r, {16'h0000, w[15:0]});
            res[2]    = mk(K_FLW, '0, '0, FL_STATUS);
            res[3]    = mk(K_FLR, '0, '0, '0);
            n_res     = CNT_W'(4);
            phase_nxt = P_FLW_POLL;
          end
        end
        default: begin
          // drop: serial byte while bus data is awaited
        end
      endcase
    end else begin
      c1 = cks_r ^ in_data.read_data[7:0];
      c2 = c1 ^ in_data.read_data[15:8];
      c3 = c2 ^ in_data.read_data[23:16];
      c4 = c3 ^ in_data.read_data[31:24];
      unique case (phase_r)
        P_RAMR_WAIT: begin
          res[0]       = mk(K_TX, in_data.read_data[7:0], '0, '0);
          res[1]       = mk(K_TX, in_data.read_data[15:8], '0, '0);
          res[2]       = mk(K_TX, in_data.read_data[23:16], '0, '0);
          res[3]       = mk(K_TX, in_data.read_data[31:24], '0, '0);
          n_res        = CNT_W'(5);
          cur_nxt      = cur1;
          byte_cnt_nxt = '0;
          word_nxt     = '0;
          if (cur1 >= end_r) begin
            res[4]    = mk(K_TX, c4, '0, '0);
            cks_nxt   = '0;
            phase_nxt = P_CMD;
          end else begin
            res[4]  = mk(K_RAMR, '0, cur1, '0);
            cks_nxt = c4;
          end
        end
        P_FLR_WAIT: begin
          res[0]       = mk(K_TX, in_data.read_data[7:0], '0, '0);
          res[1]       = mk(K_TX, in_data.read_data[15:8], '0, '0);
          n_res        = CNT_W'(3);
          cur_nxt      = cur1;
          byte_cnt_nxt = '0;
          word_nxt     = '0;
          if (cur1 >= end_r) begin
            res[2]    = mk(K_TX, c2, '0, '0);
            cks_nxt   = '0;
            phase_nxt = P_CMD;
          end else begin
            res[2]  = mk(K_FLR, '0, cur1, '0);
            cks_nxt = c2;
          end
        end
        P_FLW_POLL: begin
          if (in_data.read_data[7]) begin
            cur_nxt      = cur1;
            byte_cnt_nxt = '0;
            word_nxt     = '0;
            if (cur1 >= end_r) begin
              res[0]    = mk(K_TX, cks_r, '0, '0);
              n_res     = CNT_W'(1);
              cks_nxt   = '0;
              phase_nxt = P_CMD;
            end else begin
              phase_nxt = P_FLW_DATA;
            end
          end else begin
            res[0] = mk(K_FLW, '0, '0, FL_STATUS);
            res[1] = mk(K_FLR, '0, '0, '0);
            n_res  = CNT_W'(2);
          end
        end
        P_ERASE_POLL: begin
          if (in_data.read_data[7]) begin
            res[0]    = mk(K_TX, ERASE_DONE, '0, '0);
            res[1]    = mk(K_TX, cks_r ^ ERASE_DONE, '0, '0);
            n_res     = CNT_W'(2);
            cks_nxt   = '0;
            phase_nxt = P_CMD;
          end else begin
            res[0]  = mk(K_TX, ERASE_BUSY, '0, '0);
            res[1]  = mk(K_FLW, '0, '0, FL_STATUS);
            res[2]  = mk(K_FLR, '0, '0, '0);
            n_res   = CNT_W'(3);
            cks_nxt = cks_r ^ ERASE_BUSY;
          end
        end
        default: begin
          // drop: bus data while a serial byte is awaited
        end
      endcase
    end

    // Mark the final result of this transaction
    for (int i = 0; i < MAX_RES; i++) begin
      res[i].last = (n_res == CNT_W'(i + 1));
    end
  end

  // Control and bridge state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= P_CMD;
      command_r  <= '0;
      byte_cnt_r <= '0;
      start_r    <= '0;
      end_r      <= '0;
      cur_r      <= '0;
      word_r     <= '0;
      cks_r      <= CKS_SEED;
      cnt_r      <= '0;
    end else begin
      if (in_acc) begin
        phase_r    <= phase_nxt;
        command_r  <= command_nxt;
        byte_cnt_r <= byte_cnt_nxt;
        start_r    <= start_nxt;
        end_r      <= end_nxt;
        cur_r      <= cur_nxt;
        word_r     <= word_nxt;
        cks_r      <= cks_nxt;
        cnt_r      <= n_res;
      end else if (out_acc) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  // Result buffer: load a fresh list, else advance the head on each take
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < MAX_RES; i++) buf_r[i] <= res[i];
    end else if (out_acc) begin
      for (int i = 0; i < MAX_RES - 1; i++) buf_r[i] <= buf_r[i + 1];
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_RES))
    else $error("result count beyond buffer depth");

  a_last_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> cnt_r == CNT_W'(1))
    else $error("last flag away from the tail of the result list");

  a_tail_has_last: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'(1) |-> out_data.last)
    else $error("tail result lacks the last flag");

  a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != K_TX |-> out_data.tx_byte == 8'h00)
    else $error("bus request carries a transmit byte");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> phase_r == P_CMD && cnt_r == '0 && cks_r == CKS_SEED)
    else $error("reset left bridge state dirty");

endmodule

@@ test/tb.sv @@
module tb;
  import smtb_pkg::*;

  // Run shape
  localparam int TOTAL_ITEMS  = 420;     // transactions that the bridge acts on
  localparam int IDLE_PCT     = 15;      // chance per cycle of a gap on either side
  localparam int NOISE_PCT    = 8;       // chance of a transaction of the wrong kind
  localparam int QUIET_FROM   = 150;     // no gaps on either side in this window
  localparam int QUIET_TO     = 250;
  localparam int HOLD_AT      = 100;     // receiver holds off once from here
  localparam int HOLD_CYCLES  = 300;
  localparam int PAUSE_AT     = 300;     // sender drains the bridge once from here
  localparam int DRAIN_CYCLES = 2 * MAX_RES + 4;
  localparam int CYCLE_LIMIT  = 200_000;

  // Bridge progress through a command
  typedef enum logic [3:0] {
    PH_CMD, PH_INDEX, PH_RAMW_DATA, PH_RAMR_WAIT,
    PH_FLR_WAIT, PH_FLW_DATA, PH_FLW_POLL, PH_ERASE_POLL
  } phase_e;

  // One directed row: n_typed < 0 takes the predicted results, otherwise the
  // first n_typed entries of typed are what the bridge must return
  typedef struct packed {
    smtb_in_t        item;
    int              n_typed;
    smtb_out_t [2:0] typed;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  smtb_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  smtb_out_t out_data;

  // Predicted state of the bridge
  phase_e           ph;
  logic [7:0]       cmd_byte;
  logic [2:0]       byte_cnt;
  logic [IDX_W-1:0] first_idx;
  logic [IDX_W-1:0] stop_idx;
  logic [IDX_W-1:0] walk_idx;
  logic [31:0]      word_acc;
  logic [7:0]       checksum;

  smtb_out_t  step_results[$];          // results of the transaction just decoded
  smtb_out_t  outstanding_results[$];   // results the bridge still owes, oldest first
  stim_row_t  directed_rows[$];
  logic [7:0] index_plan[$];            // index bytes still to send for this command
  int         items_done;
  int         mismatches;
  int         cycle_count;
  bit         hold_done;
  bit         sender_paused;

  serial_memory_transfer_bridge_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic smtb_out_t make_result(input logic [2:0] kind, input logic [7:0] tx,
                                            input logic [IDX_W-1:0] idx,
                                            input logic [31:0] data, input logic fin);
    smtb_out_t r;
    r.kind       = kind;
    r.tx_byte    = tx;
    r.word_index = idx;
    r.write_data = data;
    r.last       = fin;
    return r;
  endfunction

  function automatic bit in_quiet();
    return items_done >= QUIET_FROM && items_done < QUIET_TO;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  task automatic emit(input logic [2:0] kind, input logic [7:0] tx,
                      input logic [IDX_W-1:0] idx, input logic [31:0] data);
    step_results.push_back(make_result(kind, tx, idx, data, 1'b0));
  endtask

  // Every byte sent also folds into the running checksum
  task automatic send_byte(input logic [7:0] b);
    checksum = checksum ^ b;
    emit(K_TX, b, '0, '0);
  endtask

  task automatic close_command();
    send_byte(checksum);
    ph = PH_CMD;
  endtask

  // Status poll: read-status command, then the status read itself
  task automatic poll_status();
    emit(K_FLW, '0, '0, FL_STATUS);
    emit(K_FLR, '0, '0, '0);
  endtask

  task automatic next_index(input phase_e next_ph);
    walk_idx = walk_idx + 1'b1;
    byte_cnt = '0;
    word_acc = '0;
    if (walk_idx >= stop_idx) begin
      close_command();
    end else begin
      ph = next_ph;
      if (next_ph == PH_RAMR_WAIT) emit(K_RAMR, '0, walk_idx, '0);
      else if (next_ph == PH_FLR_WAIT) emit(K_FLR, '0, walk_idx, '0);
    end
  endtask

  // Work out what one accepted transaction makes the bridge return; acted
  // goes low for a transaction of the wrong kind, which the bridge drops
  task automatic decode_transaction(input smtb_in_t t, output bit acted);
    smtb_out_t tail;
    logic      any;
    step_results.delete();
    acted = 1'b1;
    if (!t.mode) begin
      case (ph)
        PH_CMD: begin
          cmd_byte  = t.rx_byte;
          checksum  = CKS_SEED;
          byte_cnt  = '0;
          first_idx = '0;
          stop_idx  = '0;
          ph        = PH_INDEX;
        end
        PH_INDEX: begin
          checksum = checksum ^ t.rx_byte;
          if (byte_cnt < INDEX_BYTES)
            first_idx = first_idx | (IDX_W'(t.rx_byte) << (8 * byte_cnt));
          else
            stop_idx = stop_idx | (IDX_W'(t.rx_byte) << (8 * (byte_cnt - INDEX_BYTES)));
          byte_cnt++;
          if (byte_cnt >= 2 * INDEX_BYTES) begin
            // Echo the index checksum, then reseed for the command itself
            send_byte(checksum);
            checksum = CKS_SEED;
            walk_idx = first_idx;
            byte_cnt = '0;
            word_acc = '0;
            any      = first_idx < stop_idx;
            case (cmd_byte)
              C_RAM_WRITE: begin
                if (any) ph = PH_RAMW_DATA;
                else close_command();
              end
              C_RAM_READ: begin
                if (any) begin
                  ph = PH_RAMR_WAIT;
                  emit(K_RAMR, '0, walk_idx, '0);
                end else begin
                  close_command();
                end
              end
              C_FLASH_READ: begin
                emit(K_FLW, '0, '0, FL_ARRAY);
                if (any) begin
                  ph = PH_FLR_WAIT;
                  emit(K_FLR, '0, walk_idx, '0);
                end else begin
                  close_command();
                end
              end
              C_FLASH_WRITE: begin
                if (any) ph = PH_FLW_DATA;
                else close_command();
              end
              C_FLASH_ERASE: begin
                emit(K_FLW, '0, '0, FL_SETUP);
                emit(K_FLW, '0, first_idx, FL_CONFIRM);
                ph = PH_ERASE_POLL;
                poll_status();
              end
              default: close_command();
            endcase
          end
        end
        PH_RAMW_DATA, PH_FLW_DATA: begin
          checksum = checksum ^ t.rx_byte;
          word_acc = word_acc | (32'(t.rx_byte) << (8 * byte_cnt[1:0]));
          byte_cnt++;
          if (ph == PH_RAMW_DATA && byte_cnt >= 4) begin
            emit(K_RAMW, '0, walk_idx, word_acc);
            next_index(PH_RAMW_DATA);
          end else if (ph == PH_FLW_DATA && byte_cnt >= 2) begin
            emit(K_FLW, '0, '0, FL_SETUP);
            emit(K_FLW, '0, walk_idx, {16'h0, word_acc[15:0]});
            ph = PH_FLW_POLL;
            poll_status();
          end
        end
        default: acted = 1'b0;
      endcase
    end else begin
      case (ph)
        PH_RAMR_WAIT: begin
          for (int b = 0; b < 4; b++) send_byte(t.read_data[8*b +: 8]);
          next_index(PH_RAMR_WAIT);
        end
        PH_FLR_WAIT: begin
          for (int b = 0; b < 2; b++) send_byte(t.read_data[8*b +: 8]);
          next_index(PH_FLR_WAIT);
        end
        PH_FLW_POLL: begin
          if (t.read_data[7]) next_index(PH_FLW_DATA);
          else poll_status();
        end
        PH_ERASE_POLL: begin
          if (t.read_data[7]) begin
            send_byte(ERASE_DONE);
            close_command();
          end else begin
            send_byte(ERASE_BUSY);
            poll_status();
          end
        end
        default: acted = 1'b0;
      endcase
    end
    // Mark the final result of this transaction
    if (step_results.size() != 0) begin
      tail      = step_results.pop_back();
      tail.last = 1'b1;
      step_results.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_row(input logic mode, input logic [7:0] rx, input logic [31:0] rd,
                         input int n, input smtb_out_t e0 = '0,
                         input smtb_out_t e1 = '0, input smtb_out_t e2 = '0);
    stim_row_t r;
    r.item.mode      = mode;
    r.item.rx_byte   = rx;
    r.item.read_data = rd;
    r.n_typed        = n;
    r.typed          = {e2, e1, e0};
    directed_rows.push_back(r);
  endtask

  // Command byte and both indexes; only the last index byte returns anything
  task automatic add_header(input logic [7:0] cmd, input logic [IDX_W-1:0] lo,
                            input logic [IDX_W-1:0] hi, input int n_last = -1,
                            input smtb_out_t e0 = '0, input smtb_out_t e1 = '0);
    add_row(1'b0, cmd, '0, 0);
    for (int b = 0; b < INDEX_BYTES; b++) add_row(1'b0, lo[8*b +: 8], '0, 0);
    for (int b = 0; b < INDEX_BYTES - 1; b++) add_row(1'b0, hi[8*b +: 8], '0, 0);
    add_row(1'b0, hi[8*(INDEX_BYTES-1) +: 8], '0, n_last, e0, e1);
  endtask

  // Pick the next transaction from where the bridge stands: mostly what it
  // waits for, now and then the wrong kind, which it must drop
  task automatic choose_item(output smtb_in_t t);
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    bit               noise;
    t.rx_byte   = 8'($urandom);
    t.read_data = $urandom;
    noise       = $urandom_range(99) < NOISE_PCT;
    case (ph)
      PH_CMD: begin
        t.mode = noise;
        if (!noise) begin
          case ($urandom_range(5))
            0: t.rx_byte = C_RAM_WRITE;
            1: t.rx_byte = C_RAM_READ;
            2: t.rx_byte = C_FLASH_READ;
            3: t.rx_byte = C_FLASH_WRITE;
            4: t.rx_byte = C_FLASH_ERASE;
            default: ;  // any byte, mostly unknown commands
          endcase
          // Keep ranges short; cover the top of the index space and empty ranges
          case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: begin
              lo = IDX_W'($urandom_range(300));
              hi = lo + IDX_W'($urandom_range(4));
            end
            6: begin
              hi = '1;
              lo = hi - IDX_W'($urandom_range(3));
            end
            7: begin
              lo = IDX_W'($urandom_range(24'hFF_FFF0));
              hi = lo + IDX_W'($urandom_range(3, 1));
            end
            8: begin
              lo = IDX_W'($urandom);
              hi = IDX_W'($urandom_range(lo));
            end
            default: begin
              lo = IDX_W'($urandom);
              hi = lo;
            end
          endcase
          index_plan.delete();
          for (int b = 0; b < INDEX_BYTES; b++) index_plan.push_back(lo[8*b +: 8]);
          for (int b = 0; b < INDEX_BYTES; b++) index_plan.push_back(hi[8*b +: 8]);
        end
      end
      PH_INDEX: begin
        t.mode = noise;
        if (!noise && index_plan.size() != 0) t.rx_byte = index_plan.pop_front();
      end
      PH_RAMW_DATA, PH_FLW_DATA: t.mode = noise;
      default: t.mode = !noise;  // read data or flash status, bit 7 at random
    endcase
  endtask

  // Offer one transaction at the falling edge and hold it until accepted
  task automatic offer(input smtb_in_t t);
    while (!in_quiet() && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  initial begin
    smtb_in_t t;
    bit       acted;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    items_done    = 0;
    mismatches    = 0;
    sender_paused = 1'b0;
    ph            = PH_CMD;
    cmd_byte      = '0;
    byte_cnt      = '0;
    first_idx     = '0;
    stop_idx      = '0;
    walk_idx      = '0;
    word_acc      = '0;
    checksum      = CKS_SEED;

    // Bus data while a command byte is awaited: drop
    add_row(1'b1, 8'h00, 32'hFFFF_FFFF, 0);
    // Unknown command over an empty range: echo and final checksum both stay at the seed
    add_header(8'hFF, 24'hFF_FFFF, 24'hFF_FFFF, 2,
               make_result(K_TX, CKS_SEED, '0, '0, 1'b0),
               make_result(K_TX, CKS_SEED, '0, '0, 1'b1));
    // RAM write of word 0xFF_FFFE, with a stray bus transaction in the data
    add_header(C_RAM_WRITE, 24'hFF_FFFE, 24'hFF_FFFF);
    add_row(1'b0, 8'h00, '0, 0);
    add_row(1'b1, 8'h00, 32'h0, 0);
    add_row(1'b0, 8'hFF, '0, 0);
    add_row(1'b0, 8'h5A, '0, 0);
    add_row(1'b0, 8'hA5, '0, -1);
    // RAM read of word 0, with a stray serial byte while the read is out
    add_header(C_RAM_READ, 24'h00_0000, 24'h00_0001);
    add_row(1'b0, 8'h77, '0, 0);
    add_row(1'b1, 8'h00, 32'h80FF_0001, -1);
    // Flash read over an empty range still restores array mode
    add_header(C_FLASH_READ, 24'h00_0005, 24'h00_0005);
    // Flash program of one halfword: one busy poll, then ready
    add_header(C_FLASH_WRITE, 24'h00_0010, 24'h00_0011);
    add_row(1'b0, 8'h34, '0, 0);
    add_row(1'b0, 8'h12, '0, -1);
    add_row(1'b1, 8'h00, 32'h0000_007F, 2,
            make_result(K_FLW, '0, '0, FL_STATUS, 1'b0),
            make_result(K_FLR, '0, '0, '0, 1'b1));
    add_row(1'b1, 8'h00, 32'h0000_0080, -1);
    // Erase with start above end still runs; one busy poll, then done
    add_header(C_FLASH_ERASE, 24'h80_0000, 24'h00_0000);
    add_row(1'b1, 8'h00, 32'hFFFF_FF7F, 3,
            make_result(K_TX, ERASE_BUSY, '0, '0, 1'b0),
            make_result(K_FLW, '0, '0, FL_STATUS, 1'b0),
            make_result(K_FLR, '0, '0, '0, 1'b1));
    add_row(1'b1, 8'h00, 32'h0000_0080, -1);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table; the predictor keeps state on every row
    foreach (directed_rows[i]) begin
      decode_transaction(directed_rows[i].item, acted);
      if (directed_rows[i].n_typed < 0) begin
        foreach (step_results[k]) outstanding_results.push_back(step_results[k]);
      end else begin
        for (int k = 0; k < directed_rows[i].n_typed; k++)
          outstanding_results.push_back(directed_rows[i].typed[k]);
      end
      if (acted) items_done++;
      offer(directed_rows[i].item);
    end

    // Random commands with random content
    while (items_done < TOTAL_ITEMS) begin
      if (!sender_paused && items_done >= PAUSE_AT) begin
        // Hold back until the bridge has returned everything
        sender_paused = 1'b1;
        in_valid <= 1'b0;
        do @(negedge clk); while (outstanding_results.size() != 0);
      end
      choose_item(t);
      decode_transaction(t, acted);
      foreach (step_results[k]) outstanding_results.push_back(step_results[k]);
      if (acted) items_done++;
      offer(t);
    end

    in_valid <= 1'b0;
    while (outstanding_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off, a quiet window
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && items_done >= HOLD_AT) begin
        // Hold off long enough for the bridge to fill and stall its input
        hold_done = 1'b1;
        out_stall <= 1'b1;
        for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clk);
      end
      out_stall <= !in_quiet() && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    smtb_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (outstanding_results.size() == 0) begin
        $error("unexpected result: kind %0d tx 0x%0h index 0x%0h data 0x%0h",
               out_data.kind, out_data.tx_byte, out_data.word_index, out_data.write_data);
        mismatches++;
      end else begin
        want = outstanding_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_data.kind));
        check_field("tx_byte", 32'(want.tx_byte), 32'(out_data.tx_byte));
        check_field("word_index", 32'(want.word_index), 32'(out_data.word_index));
        check_field("write_data", want.write_data, out_data.write_data);
        check_field("last", 32'(want.last), 32'(out_data.last));
      end
    end
  end

  // Stop a hung run
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
design/smtb_pkg.sv
design/serial_memory_transfer_bridge_unit.sv
test/tb.sv
